// File: rtl/lhm_pkg.sv
// shared types, constants and health evaluation for the link health monitor
package lhm_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned IN_TDATA_W  = 72;
	localparam int unsigned OUT_TDATA_W = 240;

	localparam logic [CFG_IDX_W-1:0] CFG_WARNING_AGE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STALE_AGE         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE_AGE       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSPECT_FAILURES  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEGRADED_FAILURES = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_CONFIRM  = 3'd5;

	localparam logic [WORD_W-1:0] RST_WARNING_AGE       = 32'd100;
	localparam logic [WORD_W-1:0] RST_STALE_AGE         = 32'd500;
	localparam logic [WORD_W-1:0] RST_OFFLINE_AGE       = 32'd2000;
	localparam logic [WORD_W-1:0] RST_SUSPECT_FAILURES  = 32'd1;
	localparam logic [WORD_W-1:0] RST_DEGRADED_FAILURES = 32'd3;
	localparam logic [WORD_W-1:0] RST_RECOVERY_CONFIRM  = 32'd3;

	localparam logic [1:0] ACT_GOOD = 2'd1;
	localparam logic [1:0] ACT_FAIL = 2'd2;

	typedef enum logic [2:0] {
		HL_UNKNOWN  = 3'd0,
		HL_HEALTHY  = 3'd1,
		HL_SUSPECT  = 3'd2,
		HL_DEGRADED = 3'd3,
		HL_STALE    = 3'd4,
		HL_OFFLINE  = 3'd5
	} health_t;

	typedef enum logic [2:0] {
		Q_UNKNOWN    = 3'd0,
		Q_GOOD       = 3'd1,
		Q_TRANSIENT  = 3'd2,
		Q_DEGRADED   = 3'd3,
		Q_RECOVERING = 3'd4
	} quality_t;

	typedef enum logic [1:0] {
		RAW_UNKNOWN = 2'd0,
		RAW_HEALTHY = 2'd1,
		RAW_SUSPECT = 2'd2
	} raw_health_t;

	typedef struct packed {
		logic [WORD_W-1:0] warning_age;
		logic [WORD_W-1:0] stale_age;
		logic [WORD_W-1:0] offline_age;
		logic [WORD_W-1:0] suspect_failures;
		logic [WORD_W-1:0] degraded_failures;
		logic [WORD_W-1:0] recovery_confirm;
	} lhm_cfg_t;

	typedef struct packed {
		logic              has_good;
		logic [WORD_W-1:0] last_good_time;
		logic [WORD_W-1:0] last_fail_time;
		logic [WORD_W-1:0] fail_reason;
		logic [WORD_W-1:0] good_streak;
		logic [WORD_W-1:0] fail_streak;
		logic [WORD_W-1:0] good_count;
		logic [WORD_W-1:0] fail_count;
		logic              recovering;
	} lhm_state_t;

	typedef struct packed {
		logic              accepted;
		health_t           health;
		quality_t          quality;
		raw_health_t       raw_health;
		logic              seen_good;
		logic [WORD_W-1:0] good_age;
		logic [WORD_W-1:0] failure_age;
		logic [WORD_W-1:0] last_reason;
		logic [WORD_W-1:0] good_run;
		logic [WORD_W-1:0] failure_run;
		logic [WORD_W-1:0] good_total;
		logic [WORD_W-1:0] failure_total;
	} lhm_result_t;

	function automatic logic thresholds_ok(input lhm_cfg_t c);
		return (c.warning_age != '0) && (c.warning_age <= c.stale_age) &&
			(c.stale_age < c.offline_age) && (c.suspect_failures != '0) &&
			(c.suspect_failures <= c.degraded_failures) && (c.recovery_confirm != '0);
	endfunction

	function automatic health_t health_at(
		input logic              has_good,
		input logic [WORD_W-1:0] age,
		input logic              recovering,
		input logic [WORD_W-1:0] fail_streak,
		input lhm_cfg_t          c
	);
		health_t h;
		priority if (!has_good) h = HL_UNKNOWN;
		else if (age > c.offline_age) h = HL_OFFLINE;
		else if (age > c.stale_age) h = HL_STALE;
		else if (recovering) h = HL_SUSPECT;
		else if (fail_streak >= c.degraded_failures) h = HL_DEGRADED;
		else if (fail_streak >= c.suspect_failures || age > c.warning_age) h = HL_SUSPECT;
		else h = HL_HEALTHY;
		return h;
	endfunction

endpackage

// File: rtl/lhm_update.sv
// combinational state update and snapshot for one link health item
module lhm_update import lhm_pkg::*; (
	input  lhm_cfg_t          cfg,
	input  logic              cfg_ok,
	input  logic [1:0]        action,
	input  logic [WORD_W-1:0] now_time,
	input  logic [WORD_W-1:0] failure_code,
	input  lhm_state_t        st,
	output lhm_state_t        st_n,
	output lhm_result_t       res
);

	logic [WORD_W-1:0] age_prev;
	health_t           prev_health;
	logic [WORD_W-1:0] age_new;
	logic [WORD_W-1:0] fail_age_new;

	assign age_prev    = now_time - st.last_good_time;
	assign prev_health = health_at(st.has_good, age_prev, st.recovering, st.fail_streak, cfg);

	always_comb begin
		st_n = st;
		if (cfg_ok) begin
			unique case (action)
				ACT_GOOD: begin
					if (prev_health == HL_DEGRADED || prev_health == HL_STALE ||
						prev_health == HL_OFFLINE) begin
						st_n.recovering  = 1'b1;
						st_n.good_streak = '0;
					end
					st_n.has_good       = 1'b1;
					st_n.last_good_time = now_time;
					st_n.fail_streak    = '0;
					st_n.good_streak    = st_n.good_streak + 1'b1;
					st_n.good_count     = st.good_count + 1'b1;
					if (st_n.recovering && st_n.good_streak >= cfg.recovery_confirm) begin
						st_n.recovering = 1'b0;
					end
				end
				ACT_FAIL: begin
					st_n.last_fail_time = now_time;
					st_n.fail_reason    = failure_code;
					st_n.good_streak    = '0;
					if (st.fail_streak != '1) begin
						st_n.fail_streak = st.fail_streak + 1'b1;
					end
					st_n.fail_count = st.fail_count + 1'b1;
				end
				// observe and the unused code leave the state alone
				default: ;
			endcase
		end
	end

	assign age_new      = now_time - st_n.last_good_time;
	assign fail_age_new = now_time - st_n.last_fail_time;

	always_comb begin
		res = '0;
		if (cfg_ok) begin
			res.accepted = 1'b1;
			res.health   = health_at(st_n.has_good, age_new, st_n.recovering,
				st_n.fail_streak, cfg);
			priority if (!st_n.has_good) res.quality = Q_UNKNOWN;
			else if (st_n.recovering) res.quality = Q_RECOVERING;
			else if (st_n.fail_streak >= cfg.degraded_failures) res.quality = Q_DEGRADED;
			else if (st_n.fail_streak != '0) res.quality = Q_TRANSIENT;
			else res.quality = Q_GOOD;
			priority if (!st_n.has_good) res.raw_health = RAW_UNKNOWN;
			else if (st_n.fail_streak == '0) res.raw_health = RAW_HEALTHY;
			else res.raw_health = RAW_SUSPECT;
			res.seen_good     = st_n.has_good;
			res.good_age      = st_n.has_good ? age_new : '1;
			res.failure_age   = (st_n.fail_count != '0) ? fail_age_new : '1;
			res.last_reason   = st_n.fail_reason;
			res.good_run      = st_n.good_streak;
			res.failure_run   = st_n.fail_streak;
			res.good_total    = st_n.good_count;
			res.failure_total = st_n.fail_count;
		end
	end

endmodule

// File: rtl/link_health_monitor.sv
// link health monitor top level: handshake, registers and pipeline
//
// One result per item, one item per clock when the output side keeps up. An item
// is held in an input register, and its snapshot is loaded into the output register
// once that register is empty or being read, so the result is registered. The state
// update and snapshot are evaluated combinationally between those two registers. The
// threshold consistency check is combinational on the configuration registers, so a
// write applies to every item taken at or after its edge. Configuration is to be
// written only while no item is in flight; the user must keep to this, the block
// itself does not enforce it. The input stalls only when both registers hold an item
// and the output is not ready. With inconsistent thresholds every item still gets a
// result, all zero with accepted low, and the state does not change.
module link_health_monitor import lhm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// action[1:0], now_time[33:2], failure_code[65:34], zero fill
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// accepted[0], health[3:1], quality[6:4], raw_health[8:7], seen_good[9],
	// good_age[41:10], failure_age[73:42], last_reason[105:74], good_run[137:106],
	// failure_run[169:138], good_total[201:170], failure_total[233:202], zero fill
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [WORD_W-1:0]      cfg_data
);

	lhm_cfg_t          cfg_q;
	logic              cfg_ok;
	lhm_state_t        st_q;
	lhm_state_t        st_n;
	lhm_result_t       res;
	lhm_result_t       res_q;
	logic              valid_s1;
	logic [1:0]        action_s1;
	logic [WORD_W-1:0] now_time_s1;
	logic [WORD_W-1:0] failure_code_s1;
	logic              adv;

	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.warning_age       <= RST_WARNING_AGE;
			cfg_q.stale_age         <= RST_STALE_AGE;
			cfg_q.offline_age       <= RST_OFFLINE_AGE;
			cfg_q.suspect_failures  <= RST_SUSPECT_FAILURES;
			cfg_q.degraded_failures <= RST_DEGRADED_FAILURES;
			cfg_q.recovery_confirm  <= RST_RECOVERY_CONFIRM;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WARNING_AGE:       cfg_q.warning_age       <= cfg_data;
				CFG_STALE_AGE:         cfg_q.stale_age         <= cfg_data;
				CFG_OFFLINE_AGE:       cfg_q.offline_age       <= cfg_data;
				CFG_SUSPECT_FAILURES:  cfg_q.suspect_failures  <= cfg_data;
				CFG_DEGRADED_FAILURES: cfg_q.degraded_failures <= cfg_data;
				CFG_RECOVERY_CONFIRM:  cfg_q.recovery_confirm  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ok = thresholds_ok(cfg_q);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1       <= s_tdata[1:0];
			now_time_s1     <= s_tdata[33:2];
			failure_code_s1 <= s_tdata[65:34];
		end
	end

	lhm_update u_update (
		.cfg          (cfg_q),
		.cfg_ok       (cfg_ok),
		.action       (action_s1),
		.now_time     (now_time_s1),
		.failure_code (failure_code_s1),
		.st           (st_q),
		.st_n         (st_n),
		.res          (res)
	);

	// link state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (adv) begin
			st_q <= st_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_tdata = {6'd0, res_q.failure_total, res_q.good_total, res_q.failure_run,
		res_q.good_run, res_q.last_reason, res_q.failure_age, res_q.good_age,
		res_q.seen_good, res_q.raw_health, res_q.quality, res_q.health, res_q.accepted};

	// a rejected snapshot carries nothing else
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res_q.accepted |-> res_q[$bits(lhm_result_t)-2:0] == '0)
		else $error("rejected result with non-zero fields");

	// state moves only when an item is evaluated
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(st_q))
		else $error("link state changed without an item");

	// once a good exchange is seen it stays seen
	a_good_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(st_q.has_good))
		else $error("has_good cleared");

	// recovery is only pending after a good exchange
	a_recover_good: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.recovering |-> st_q.has_good)
		else $error("recovery pending with no good exchange");

	// the state is left untouched while thresholds are inconsistent
	a_bad_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !cfg_ok |=> $stable(st_q))
		else $error("state changed under inconsistent thresholds");

endmodule

// File: test/lhm_checker.sv
// link health monitor checker: tracks the link state, predicts each snapshot and compares
module lhm_checker import lhm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [WORD_W-1:0]      cfg_data,
	output int                     mismatches,
	output int                     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	lhm_cfg_t    limits;
	lhm_state_t  link;
	lhm_result_t expected_snapshots[$];

	initial mismatches = 0;

	function automatic void set_limit(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		case (idx)
			CFG_WARNING_AGE:       limits.warning_age = val;
			CFG_STALE_AGE:         limits.stale_age = val;
			CFG_OFFLINE_AGE:       limits.offline_age = val;
			CFG_SUSPECT_FAILURES:  limits.suspect_failures = val;
			CFG_DEGRADED_FAILURES: limits.degraded_failures = val;
			CFG_RECOVERY_CONFIRM:  limits.recovery_confirm = val;
			default: ;
		endcase
	endfunction

	function automatic logic limits_consistent();
		if (limits.warning_age == 0 || limits.suspect_failures == 0 || limits.recovery_confirm == 0)
			return 1'b0;
		return limits.warning_age <= limits.stale_age && limits.stale_age < limits.offline_age &&
			limits.suspect_failures <= limits.degraded_failures;
	endfunction

	function automatic health_t grade_at(input logic [WORD_W-1:0] now);
		logic [WORD_W-1:0] age;
		age = now - link.last_good_time;
		if (!link.has_good)
			return HL_UNKNOWN;
		if (age > limits.offline_age)
			return HL_OFFLINE;
		if (age > limits.stale_age)
			return HL_STALE;
		if (link.recovering)
			return HL_SUSPECT;
		if (link.fail_streak >= limits.degraded_failures)
			return HL_DEGRADED;
		if (link.fail_streak >= limits.suspect_failures || age > limits.warning_age)
			return HL_SUSPECT;
		return HL_HEALTHY;
	endfunction

	// applies one event to the link state and returns the snapshot taken after it
	function automatic lhm_result_t predict_snapshot(input logic [1:0] action,
			input logic [WORD_W-1:0] now, input logic [WORD_W-1:0] code);
		lhm_result_t r;
		health_t     prior;
		r = '0;
		if (!limits_consistent())
			return r;
		if (action == ACT_GOOD) begin
			prior = grade_at(now);
			if (prior == HL_DEGRADED || prior == HL_STALE || prior == HL_OFFLINE) begin
				link.recovering = 1'b1;
				link.good_streak = '0;
			end
			link.has_good = 1'b1;
			link.last_good_time = now;
			link.fail_streak = '0;
			link.good_streak = link.good_streak + 1;
			link.good_count = link.good_count + 1;
			if (link.recovering && link.good_streak >= limits.recovery_confirm)
				link.recovering = 1'b0;
		end else if (action == ACT_FAIL) begin
			link.last_fail_time = now;
			link.fail_reason = code;
			link.good_streak = '0;
			if (link.fail_streak != '1)
				link.fail_streak = link.fail_streak + 1;
			link.fail_count = link.fail_count + 1;
		end
		r.accepted = 1'b1;
		r.health = grade_at(now);
		if (!link.has_good)
			r.quality = Q_UNKNOWN;
		else if (link.recovering)
			r.quality = Q_RECOVERING;
		else if (link.fail_streak >= limits.degraded_failures)
			r.quality = Q_DEGRADED;
		else if (link.fail_streak != 0)
			r.quality = Q_TRANSIENT;
		else
			r.quality = Q_GOOD;
		if (!link.has_good)
			r.raw_health = RAW_UNKNOWN;
		else if (link.fail_streak == 0)
			r.raw_health = RAW_HEALTHY;
		else
			r.raw_health = RAW_SUSPECT;
		r.seen_good = link.has_good;
		r.good_age = link.has_good ? now - link.last_good_time : '1;
		r.failure_age = link.fail_count != 0 ? now - link.last_fail_time : '1;
		r.last_reason = link.fail_reason;
		r.good_run = link.good_streak;
		r.failure_run = link.fail_streak;
		r.good_total = link.good_count;
		r.failure_total = link.fail_count;
		return r;
	endfunction

	function automatic lhm_result_t unpack_snapshot(input logic [OUT_TDATA_W-1:0] d);
		lhm_result_t r;
		r.accepted = d[0];
		r.health = health_t'(d[3:1]);
		r.quality = quality_t'(d[6:4]);
		r.raw_health = raw_health_t'(d[8:7]);
		r.seen_good = d[9];
		r.good_age = d[41:10];
		r.failure_age = d[73:42];
		r.last_reason = d[105:74];
		r.good_run = d[137:106];
		r.failure_run = d[169:138];
		r.good_total = d[201:170];
		r.failure_total = d[233:202];
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void compare_snapshot(input lhm_result_t want, input lhm_result_t got);
		check_field("accepted", WORD_W'(want.accepted), WORD_W'(got.accepted));
		check_field("health", WORD_W'(want.health), WORD_W'(got.health));
		check_field("quality", WORD_W'(want.quality), WORD_W'(got.quality));
		check_field("raw_health", WORD_W'(want.raw_health), WORD_W'(got.raw_health));
		check_field("seen_good", WORD_W'(want.seen_good), WORD_W'(got.seen_good));
		check_field("good_age", want.good_age, got.good_age);
		check_field("failure_age", want.failure_age, got.failure_age);
		check_field("last_reason", want.last_reason, got.last_reason);
		check_field("good_run", want.good_run, got.good_run);
		check_field("failure_run", want.failure_run, got.failure_run);
		check_field("good_total", want.good_total, got.good_total);
		check_field("failure_total", want.failure_total, got.failure_total);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lhm_result_t want;
		if (!arst_n) begin
			limits.warning_age = RST_WARNING_AGE;
			limits.stale_age = RST_STALE_AGE;
			limits.offline_age = RST_OFFLINE_AGE;
			limits.suspect_failures = RST_SUSPECT_FAILURES;
			limits.degraded_failures = RST_DEGRADED_FAILURES;
			limits.recovery_confirm = RST_RECOVERY_CONFIRM;
			link = '0;
			expected_snapshots.delete();
			outstanding = 0;
		end else begin
			if (cfg_we)
				set_limit(cfg_index, cfg_data);
			// results first, so a transfer out never meets an expectation pushed at the same edge
			if (m_tvalid && m_tready) begin
				if (expected_snapshots.size() == 0) begin
					$display("%0t ns: snapshot expected none actual %0h", $time, m_tdata);
					mismatches++;
				end else begin
					want = expected_snapshots.pop_front();
					compare_snapshot(want, unpack_snapshot(m_tdata));
				end
			end
			if (s_tvalid && s_tready)
				expected_snapshots.push_back(predict_snapshot(s_tdata[1:0], s_tdata[33:2],
					s_tdata[65:34]));
			outstanding = expected_snapshots.size();
		end
	end

endmodule

// File: test/testbench.sv
// link health monitor testbench: event stimulus, output back-pressure and the verdict
module testbench import lhm_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam logic [1:0] ACT_OBSERVE = 2'd0;
	localparam logic [1:0] ACT_SPARE   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;
	localparam lhm_cfg_t DEFAULT_LIMITS = '{
		warning_age: RST_WARNING_AGE, stale_age: RST_STALE_AGE, offline_age: RST_OFFLINE_AGE,
		suspect_failures: RST_SUSPECT_FAILURES, degraded_failures: RST_DEGRADED_FAILURES,
		recovery_confirm: RST_RECOVERY_CONFIRM};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [WORD_W-1:0]      cfg_data = '0;
	int                     mismatches;
	int                     outstanding;

	int unsigned       cycles = 0;
	logic [WORD_W-1:0] now_ms = '0;
	bit                calm_tx = 1'b1;
	bit                calm_rx = 1'b1;
	int                rx_hold = 0;

	link_health_monitor i_dut (.*);
	lhm_checker i_checker (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 15);
		return $urandom_range(20, 60);
	endfunction

	// receiver: random stalls, or a long hold-off when asked for one
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end else if (calm_rx || $urandom_range(0, 3) != 0) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				n = pick_gap();
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic send_event(input logic [1:0] action, input logic [WORD_W-1:0] now,
			input logic [WORD_W-1:0] code);
		int gap;
		s_tdata <= {{(IN_TDATA_W - 66){1'b0}}, code, now, action};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		gap = calm_tx ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// the count is read only after the last transfer in, once it is settled
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	// registers change only with the pipe empty
	task automatic retune(input lhm_cfg_t c);
		drain();
		put_reg(CFG_WARNING_AGE, c.warning_age);
		put_reg(CFG_STALE_AGE, c.stale_age);
		put_reg(CFG_OFFLINE_AGE, c.offline_age);
		put_reg(CFG_SUSPECT_FAILURES, c.suspect_failures);
		put_reg(CFG_DEGRADED_FAILURES, c.degraded_failures);
		put_reg(CFG_RECOVERY_CONFIRM, c.recovery_confirm);
		put_reg(CFG_UNUSED_LO, $urandom);
		put_reg(CFG_UNUSED_HI, $urandom);
		cfg_we <= 1'b0;
		repeat (2) @(posedge clk);
	endtask

	function automatic logic [WORD_W-1:0] advance_clock(input int unsigned span);
		int r;
		r = $urandom_range(0, 99);
		if (r < 85)
			now_ms = now_ms + $urandom_range(0, span);
		else if (r < 97)
			now_ms = now_ms + $urandom_range(span, 4 * span);
		else
			now_ms = $urandom;
		return now_ms;
	endfunction

	// runs of one action with random times and codes, plus stray single events
	task automatic random_traffic(input int count, input int unsigned span);
		int         left;
		int         run;
		int         r;
		logic [1:0] act;
		left = count;
		while (left > 0) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				act = ACT_GOOD;
			else if (r < 80)
				act = ACT_FAIL;
			else if (r < 93)
				act = ACT_OBSERVE;
			else
				act = ACT_SPARE;
			run = (r >= 93) ? 1 : $urandom_range(1, 6);
			for (int k = 0; k < run && left > 0; k++) begin
				send_event(act, advance_clock(span), $urandom);
				left--;
			end
		end
	endtask

	function automatic lhm_cfg_t random_limits();
		lhm_cfg_t c;
		c.warning_age = $urandom_range(1, 300);
		c.stale_age = c.warning_age + $urandom_range(0, 500);
		c.offline_age = c.stale_age + $urandom_range(1, 1500);
		c.suspect_failures = $urandom_range(1, 4);
		c.degraded_failures = c.suspect_failures + $urandom_range(0, 4);
		c.recovery_confirm = $urandom_range(1, 5);
		return c;
	endfunction

	initial begin
		lhm_cfg_t c;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		send_event(ACT_OBSERVE, 32'd0, 32'd0);
		send_event(ACT_FAIL, 32'd5, 32'hFFFF_FFFF);
		send_event(ACT_SPARE, 32'd10, 32'h1234_5678);
		send_event(ACT_GOOD, 32'd20, 32'd0);
		send_event(ACT_OBSERVE, 32'd150, 32'd0);
		send_event(ACT_GOOD, 32'd160, 32'd0);
		send_event(ACT_FAIL, 32'd170, 32'd0);
		send_event(ACT_FAIL, 32'd180, 32'h5A5A_5A5A);
		send_event(ACT_FAIL, 32'd190, 32'hA5A5_A5A5);
		send_event(ACT_GOOD, 32'd200, 32'd0);
		send_event(ACT_GOOD, 32'd210, 32'd0);
		send_event(ACT_GOOD, 32'd220, 32'd0);
		send_event(ACT_OBSERVE, 32'd720, 32'd0);
		send_event(ACT_OBSERVE, 32'd721, 32'd0);
		send_event(ACT_OBSERVE, 32'd2221, 32'd0);
		send_event(ACT_GOOD, 32'd2222, 32'd0);
		send_event(ACT_GOOD, 32'hFFFF_FFF0, 32'd0);
		send_event(ACT_GOOD, 32'h0000_0010, 32'd0);
		send_event(ACT_FAIL, 32'hFFFF_FFFF, 32'h8000_0000);
		send_event(ACT_OBSERVE, 32'd0, 32'hFFFF_FFFF);
		send_event(ACT_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		now_ms = 32'd0;

		calm_tx = 1'b0;
		calm_rx = 1'b0;
		random_traffic(150, 150);
		calm_tx = 1'b1;
		calm_rx = 1'b1;
		random_traffic(100, 150);
		calm_tx = 1'b0;
		calm_rx = 1'b0;
		random_traffic(250, 150);

		// output held off while events keep coming, so the input side backs up
		rx_hold = 200;
		calm_tx = 1'b1;
		random_traffic(40, 150);
		calm_tx = 1'b0;

		for (int k = 0; k < 6; k++) begin
			c = DEFAULT_LIMITS;
			case (k)
				0: c.warning_age = '0;
				1: c.warning_age = c.stale_age + 1;
				2: c.stale_age = c.offline_age;
				3: c.suspect_failures = '0;
				4: c.suspect_failures = c.degraded_failures + 1;
				default: c.recovery_confirm = '0;
			endcase
			retune(c);
			random_traffic(8, 150);
		end

		retune('{warning_age: 32'd1, stale_age: 32'd1, offline_age: 32'd2,
			suspect_failures: 32'd1, degraded_failures: 32'd1, recovery_confirm: 32'd1});
		random_traffic(150, 2);

		retune('{warning_age: 32'hFFFF_FFFE, stale_age: 32'hFFFF_FFFE, offline_age: '1,
			suspect_failures: '1, degraded_failures: '1, recovery_confirm: '1});
		random_traffic(100, 32'h3FFF_FFFF);

		repeat (4) begin
			c = random_limits();
			retune(c);
			random_traffic(150, c.offline_age / 3 + 1);
		end

		repeat (2) begin
			c = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			retune(c);
			random_traffic(40, 1000);
		end

		retune(DEFAULT_LIMITS);
		random_traffic(200, 150);

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
